>>> design/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; included by backslash_escape_decoder, which carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define BSD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true outside reset
`define BSD_NEVER(lbl, clk, rst_n, cond, msg) \
	`BSD_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

>>> design/bsd_pkg.sv
// types, character codes and helper functions of the backslash escape decoder
// no dependencies; used by bsd_step and the top level
`default_nettype none

package bsd_pkg;

	localparam int unsigned RES_MAX = 5;
	localparam int unsigned CODE_BYTES = 4;

	localparam logic [24:0] CODE_MAX = 25'h10FFFF;
	localparam logic [10:0] OCT_MAX = 11'o377;
	localparam logic [3:0] OCT_DIGITS = 4'd3;

	// input characters
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LB = 8'h62;
	localparam logic [7:0] CH_LF = 8'h66;
	localparam logic [7:0] CH_LN = 8'h6E;
	localparam logic [7:0] CH_LR = 8'h72;
	localparam logic [7:0] CH_LT = 8'h74;
	localparam logic [7:0] CH_LV = 8'h76;
	localparam logic [7:0] CH_LX = 8'h78;
	localparam logic [7:0] CH_LU = 8'h75;
	localparam logic [7:0] CH_UU = 8'h55;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_7 = 8'h37;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;

	// control codes produced by the simple escapes
	localparam logic [7:0] CC_BEL = 8'h07;
	localparam logic [7:0] CC_BS = 8'h08;
	localparam logic [7:0] CC_FF = 8'h0C;
	localparam logic [7:0] CC_LF = 8'h0A;
	localparam logic [7:0] CC_CR = 8'h0D;
	localparam logic [7:0] CC_HT = 8'h09;
	localparam logic [7:0] CC_VT = 8'h0B;

	typedef enum logic [2:0] {
		MODE_PLAIN = 3'd0,
		MODE_BSL = 3'd1,
		MODE_CONT = 3'd2,
		MODE_HX = 3'd3,
		MODE_HU = 3'd4,
		MODE_HBU = 3'd5,
		MODE_OCT = 3'd6
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic [20:0] cv;
		logic [3:0] dc;
	} state_t;

	typedef struct packed {
		logic [CODE_BYTES-1:0][7:0] bytes;
		logic [2:0] len;
	} code_t;

	typedef struct packed {
		logic [RES_MAX-1:0][7:0] bytes;
		logic [2:0] count;
	} res_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic run_last;
		logic stream_end;
	} out_item_t;

	// {digit ok, digit value}
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [7:0] t;
		t = 8'h00;
		if (b >= CH_0 && b <= CH_9) begin
			t = b - CH_0;
			return {1'b1, t[3:0]};
		end
		if (b >= CH_LA && b <= CH_LF) begin
			t = b - CH_LA + 8'd10;
			return {1'b1, t[3:0]};
		end
		if (b >= CH_UA && b <= CH_UF) begin
			t = b - CH_UA + 8'd10;
			return {1'b1, t[3:0]};
		end
		return 5'b0;
	endfunction

	function automatic logic [3:0] hex_limit(input mode_t m);
		if (m == MODE_HX) return 4'd2;
		if (m == MODE_HU) return 4'd4;
		return 4'd8;
	endfunction

	function automatic logic [7:0] bare_letter(input mode_t m);
		if (m == MODE_HX) return CH_LX;
		if (m == MODE_HU) return CH_LU;
		return CH_UU;
	endfunction

	// bytes of a finished digit run: raw byte for \x and octal, utf-8 otherwise
	function automatic code_t encode_code(input mode_t m, input logic [20:0] cv);
		code_t c;
		c = '0;
		if (m == MODE_HX || m == MODE_OCT) begin
			c.bytes[0] = cv[7:0];
			c.len = 3'd1;
		end else if (cv < 21'h80) begin
			c.bytes[0] = cv[7:0];
			c.len = 3'd1;
		end else if (cv < 21'h800) begin
			c.bytes[0] = {3'b110, cv[10:6]};
			c.bytes[1] = {2'b10, cv[5:0]};
			c.len = 3'd2;
		end else if (cv < 21'h10000) begin
			c.bytes[0] = {4'b1110, cv[15:12]};
			c.bytes[1] = {2'b10, cv[11:6]};
			c.bytes[2] = {2'b10, cv[5:0]};
			c.len = 3'd3;
		end else begin
			c.bytes[0] = {5'b11110, cv[20:18]};
			c.bytes[1] = {2'b10, cv[17:12]};
			c.bytes[2] = {2'b10, cv[11:6]};
			c.bytes[3] = {2'b10, cv[5:0]};
			c.len = 3'd4;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> design/bsd_stream_if.sv
// valid/ready channel carrying one item of a given payload type
// depends on nothing; instantiated with bsd_pkg item types
`default_nettype none

interface bsd_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/bsd_step.sv
// next-state and result logic for one input byte of the escape decoder
// depends on bsd_pkg
`default_nettype none

module bsd_step (
	input bsd_pkg::state_t cur,
	input logic [7:0] data_byte,
	input logic data_last,
	output bsd_pkg::state_t nxt,
	output bsd_pkg::res_t res
);

	always_comb begin
		bsd_pkg::mode_t m;
		logic [20:0] cv;
		logic [3:0] dc;
		logic [2:0] n;
		logic [bsd_pkg::RES_MAX-1:0][7:0] rb;
		logic pre_push;
		logic [7:0] pre_byte;
		logic emit_step;
		logic [20:0] emit_cv;
		logic fresh;
		logic [4:0] hd;
		logic [24:0] nv_hex;
		logic [10:0] nv_oct;
		logic is_oct;
		logic flush_letter;
		logic flush_emit;
		bsd_pkg::code_t enc_s;
		bsd_pkg::code_t enc_f;

		m = cur.mode;
		cv = cur.cv;
		dc = cur.dc;
		n = 3'd0;
		rb = '0;
		pre_push = 1'b0;
		pre_byte = data_byte;
		emit_step = 1'b0;
		emit_cv = cur.cv;
		fresh = 1'b0;
		flush_letter = 1'b0;
		flush_emit = 1'b0;
		hd = bsd_pkg::hex_digit(data_byte);
		nv_hex = {cur.cv, hd[3:0]};
		nv_oct = {cur.cv[7:0], data_byte[2:0]};
		is_oct = (data_byte >= bsd_pkg::CH_0) && (data_byte <= bsd_pkg::CH_7);

		case (cur.mode)
			bsd_pkg::MODE_BSL: begin
				m = bsd_pkg::MODE_PLAIN;
				cv = '0;
				dc = '0;
				pre_push = 1'b1;
				unique case (data_byte)
					bsd_pkg::CH_LA: pre_byte = bsd_pkg::CC_BEL;
					bsd_pkg::CH_LB: pre_byte = bsd_pkg::CC_BS;
					bsd_pkg::CH_LF: pre_byte = bsd_pkg::CC_FF;
					bsd_pkg::CH_LN: pre_byte = bsd_pkg::CC_LF;
					bsd_pkg::CH_LR: pre_byte = bsd_pkg::CC_CR;
					bsd_pkg::CH_LT: pre_byte = bsd_pkg::CC_HT;
					bsd_pkg::CH_LV: pre_byte = bsd_pkg::CC_VT;
					bsd_pkg::CH_NL: begin
						pre_byte = bsd_pkg::CH_SP;
						m = bsd_pkg::MODE_CONT;
					end
					bsd_pkg::CH_LX: begin
						pre_push = 1'b0;
						m = bsd_pkg::MODE_HX;
					end
					bsd_pkg::CH_LU: begin
						pre_push = 1'b0;
						m = bsd_pkg::MODE_HU;
					end
					bsd_pkg::CH_UU: begin
						pre_push = 1'b0;
						m = bsd_pkg::MODE_HBU;
					end
					default: begin
						if (is_oct) begin
							pre_push = 1'b0;
							m = bsd_pkg::MODE_OCT;
							cv = {18'b0, data_byte[2:0]};
							dc = 4'd1;
						end
					end
				endcase
			end
			bsd_pkg::MODE_CONT: begin
				// blanks after backslash-newline are swallowed
				if (data_byte != bsd_pkg::CH_SP && data_byte != bsd_pkg::CH_TAB) begin
					fresh = 1'b1;
				end
			end
			bsd_pkg::MODE_HX, bsd_pkg::MODE_HU, bsd_pkg::MODE_HBU: begin
				if (!hd[4] || (cur.mode == bsd_pkg::MODE_HBU && nv_hex > bsd_pkg::CODE_MAX)) begin
					if (cur.dc == 4'd0) begin
						pre_push = 1'b1;
						pre_byte = bsd_pkg::bare_letter(cur.mode);
					end else begin
						emit_step = 1'b1;
					end
					fresh = 1'b1;
				end else begin
					cv = nv_hex[20:0];
					dc = cur.dc + 4'd1;
					if (dc >= bsd_pkg::hex_limit(cur.mode)) begin
						emit_step = 1'b1;
						emit_cv = cv;
						m = bsd_pkg::MODE_PLAIN;
						cv = '0;
						dc = '0;
					end
				end
			end
			bsd_pkg::MODE_OCT: begin
				if (is_oct && nv_oct <= bsd_pkg::OCT_MAX && cur.dc < bsd_pkg::OCT_DIGITS) begin
					cv = {10'b0, nv_oct};
					dc = cur.dc + 4'd1;
					if (dc >= bsd_pkg::OCT_DIGITS) begin
						emit_step = 1'b1;
						emit_cv = cv;
						m = bsd_pkg::MODE_PLAIN;
						cv = '0;
						dc = '0;
					end
				end else begin
					emit_step = 1'b1;
					fresh = 1'b1;
				end
			end
			default: fresh = 1'b1;
		endcase

		// results in order: escaped byte or bare letter, code of the run, the fresh byte, the flush
		if (pre_push) begin
			rb[n] = pre_byte;
			n = n + 3'd1;
		end

		enc_s = bsd_pkg::encode_code(cur.mode, emit_cv);
		for (int k = 0; k < bsd_pkg::CODE_BYTES; k++) begin
			if (emit_step && k < int'(enc_s.len) && n < 3'(bsd_pkg::RES_MAX)) begin
				rb[n] = enc_s.bytes[k];
				n = n + 3'd1;
			end
		end

		if (fresh) begin
			m = bsd_pkg::MODE_PLAIN;
			cv = '0;
			dc = '0;
			if (data_byte == bsd_pkg::CH_BSL) begin
				m = bsd_pkg::MODE_BSL;
			end else if (n < 3'(bsd_pkg::RES_MAX)) begin
				rb[n] = data_byte;
				n = n + 3'd1;
			end
		end

		if (data_last) begin
			if (m == bsd_pkg::MODE_HX || m == bsd_pkg::MODE_HU || m == bsd_pkg::MODE_HBU) begin
				flush_letter = (dc == 4'd0);
				flush_emit = (dc != 4'd0);
			end else if (m == bsd_pkg::MODE_OCT) begin
				flush_emit = 1'b1;
			end
		end

		if (flush_letter && n < 3'(bsd_pkg::RES_MAX)) begin
			rb[n] = bsd_pkg::bare_letter(m);
			n = n + 3'd1;
		end

		enc_f = bsd_pkg::encode_code(m, cv);
		for (int k = 0; k < bsd_pkg::CODE_BYTES; k++) begin
			if (flush_emit && k < int'(enc_f.len) && n < 3'(bsd_pkg::RES_MAX)) begin
				rb[n] = enc_f.bytes[k];
				n = n + 3'd1;
			end
		end

		if (data_last) begin
			m = bsd_pkg::MODE_PLAIN;
			cv = '0;
			dc = '0;
		end

		nxt.mode = m;
		nxt.cv = cv;
		nxt.dc = dc;
		res.bytes = rb;
		res.count = n;
	end

endmodule

`default_nettype wire

>>> design/backslash_escape_decoder.sv
// Timing: an accepted item is registered in the input stage, then decoded into the result
// buffer once that is free; results are offered one per cycle while decoded.ready is high.
// Throughput: one item per cycle while each item gives at most one result and the output is not
// stalled; an item giving k results (up to 5, for a utf-8 code followed by a byte) holds the
// result buffer until all k are taken. Items giving no result leave the buffer free.
// Reset: arst_n clears the input stage, result buffer and decoder to plain text mode.
`default_nettype none
`include "assert_macros.svh"

// top level of the backslash escape decoder
// depends on bsd_pkg, bsd_stream_if and bsd_step
module backslash_escape_decoder (
	input logic clk,
	input logic arst_n,
	bsd_stream_if.sink text,
	bsd_stream_if.source decoded
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;

	bsd_pkg::state_t state_q;
	bsd_pkg::state_t state_nxt;
	bsd_pkg::res_t step_res;

	logic [bsd_pkg::RES_MAX-1:0][7:0] bytes_q;
	logic [2:0] cnt_q;
	logic [2:0] idx_q;
	logic end_q;

	logic out_fire;
	logic run_done;
	logic drain_done;
	logic buf_free;
	logic s1_go;
	bsd_pkg::out_item_t out_item;

	bsd_step u_step (
		.cur(state_q),
		.data_byte(byte_s1),
		.data_last(last_s1),
		.nxt(state_nxt),
		.res(step_res)
	);

	assign run_done = (idx_q == cnt_q - 3'd1);
	assign out_fire = decoded.valid && decoded.ready;
	assign drain_done = out_fire && run_done;
	assign buf_free = (cnt_q == 3'd0) || drain_done;
	assign s1_go = valid_s1 && buf_free;
	assign text.ready = !valid_s1 || s1_go;

	assign out_item.out_byte = bytes_q[idx_q];
	assign out_item.run_last = run_done;
	assign out_item.stream_end = run_done && end_q;
	assign decoded.valid = (cnt_q != 3'd0);
	assign decoded.data = out_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.data.in_byte;
			last_s1 <= text.data.in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: bsd_pkg::MODE_PLAIN, cv: '0, dc: '0};
			cnt_q <= '0;
			idx_q <= '0;
			end_q <= 1'b0;
		end else if (s1_go) begin
			state_q <= state_nxt;
			cnt_q <= step_res.count;
			idx_q <= '0;
			end_q <= last_s1;
		end else if (out_fire) begin
			if (run_done) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			bytes_q <= step_res.bytes;
		end
	end

	`BSD_NEVER(a_cnt_range, clk, arst_n, cnt_q > 3'(bsd_pkg::RES_MAX), "result count out of range")
	`BSD_NEVER(a_idx_range, clk, arst_n, cnt_q != 3'd0 && idx_q >= cnt_q, "result index past count")
	`BSD_ASSERT(a_s1_hold, clk, arst_n, valid_s1 && !buf_free |=> valid_s1 && $stable(byte_s1), "input stage lost while buffer busy")
	`BSD_ASSERT(a_last_clears, clk, arst_n, s1_go && last_s1 |=> state_q.mode == bsd_pkg::MODE_PLAIN && state_q.dc == 4'd0, "stream end left escape pending")
	`BSD_NEVER(a_dc_range, clk, arst_n, state_q.dc > 4'd8, "digit count out of range")

endmodule

`default_nettype wire
